// ===== rtl/htfd_pkg.sv =====
// Shared types, constants and the CRC-8 helper of the humidity/temperature frame decoder.
// Used by every module of the decoder; depends on nothing.
package htfd_pkg;

    // Frame layout: bytes 0 to 5 are covered by the CRC, byte 6 carries the CRC.
    localparam logic [2:0] FRAME_LAST = 3'd6;
    localparam logic [7:0] CRC_POLY   = 8'h31;
    localparam logic [7:0] CRC_INIT   = 8'hFF;
    localparam logic [7:0] BUSY_MASK_RESET = 8'h80;

    // Conversion scale factors (fixed point, 20 fractional bits in the raw field).
    localparam logic [13:0] HUM_SCALE   = 14'd10000;
    localparam logic [14:0] TEMP_SCALE  = 15'd20000;
    localparam logic [14:0] TEMP_OFFSET = 15'd5000;

    // Result status codes.
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BUSY    = 2'd1;
    localparam logic [1:0] STATUS_CRC_ERR = 2'd2;

    // Register map: register index decoded from the address.
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic        REG_BUSY_MASK = 1'b0;

    // A completed frame as it leaves the byte assembler.
    typedef struct packed {
        logic [1:0]  status;
        logic [19:0] humidity_raw;
        logic [19:0] temperature_raw;
        logic [7:0]  crc_computed;
    } t_frame;

    // One CRC-8 update over a byte, MSB first, no final XOR.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/htfd_channels.sv =====
// Valid/ready channel interfaces of the frame decoder: received bytes in, decoded frames out.
// Stand-alone; the field widths are those of the decoder's input and result items.
interface htfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface htfd_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [19:0]        humidity_raw;
    logic [19:0]        temperature_raw;
    logic [13:0]        humidity_centi;
    logic signed [14:0] temperature_centi;
    logic [7:0]         crc_computed;

    modport source (output valid, output status, output humidity_raw, output temperature_raw,
                    output humidity_centi, output temperature_centi, output crc_computed,
                    input ready);
    modport sink   (input valid, input status, input humidity_raw, input temperature_raw,
                    input humidity_centi, input temperature_centi, input crc_computed,
                    output ready);
endinterface

// ===== rtl/humidity_temp_frame_decoder.sv =====
// Humidity/temperature reply decoder, top level: APB register block, byte assembler and
// conversion stage. Depends on htfd_pkg, the channel interfaces and the three submodules.
//
// The decoder takes the sensor's seven-byte measurement reply one byte per transfer and
// accepts a byte in every cycle while no frame record waits downstream; the assembler
// updates the running CRC-8 with a fully unrolled byte step. On the seventh byte a frame
// record is registered, and the conversion stage then registers and presents the result with
// status (ok, busy, CRC mismatch), both raw 20-bit fields, humidity and temperature in
// hundredths and the computed CRC. frame_start forces the byte to be read as the status
// byte; a byte after a complete reply starts a new one on its own. busy_mask sits at
// byte address 0; the user must write it only while no reply is in progress, the block
// itself does not enforce this.
module humidity_temp_frame_decoder (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    htfd_in_if.sink                            i_in,
    htfd_out_if.source                         o_out,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [htfd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [htfd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [htfd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import htfd_pkg::*;

    logic [7:0] busy_mask;
    logic       rec_valid;
    logic       rec_ready;
    t_frame     rec;

    // Configuration registers.
    htfd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_busy_mask (busy_mask)
    );

    // Byte position, CRC and field assembly.
    htfd_assembler u_asm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_busy_mask (busy_mask),
        .o_rec_valid (rec_valid),
        .i_rec_ready (rec_ready),
        .o_rec       (rec)
    );

    // Scaling and result register.
    htfd_convert u_conv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_valid (rec_valid),
        .o_rec_ready (rec_ready),
        .i_rec       (rec),
        .o_out       (o_out)
    );

    // A busy mask of zero never reports a busy sensor.
    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rec_valid && busy_mask == 8'd0 && $stable(busy_mask)) |-> (rec.status != STATUS_BUSY))
        else $error("busy reported with an empty mask");

endmodule

// ===== rtl/htfd_cfg_regs.sv =====
// APB register block of the frame decoder: holds the busy mask.
// Depends on htfd_pkg for the register map and reset value.
module htfd_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [htfd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [htfd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [htfd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output logic [7:0]                         o_busy_mask
);
    import htfd_pkg::*;

    logic [7:0] r_busy_mask;
    logic       wr_en;
    logic       sel_busy;

    // Word index comes from the top address bit; the byte offset bits are ignored.
    assign sel_busy = (paddr[APB_ADDR_W-1] == REG_BUSY_MASK);
    assign wr_en    = psel && penable && pwrite && sel_busy;
    assign pready   = 1'b1;

    // Register write in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy_mask <= BUSY_MASK_RESET;
        end else if (wr_en) begin
            r_busy_mask <= pwdata[7:0];
        end
    end

    // Read data, zero for unmapped words.
    always_comb begin
        prdata = '0;
        if (sel_busy) begin
            prdata = {{(APB_DATA_W-8){1'b0}}, r_busy_mask};
        end
    end

    assign o_busy_mask = r_busy_mask;

endmodule

// ===== rtl/htfd_assembler.sv =====
// Byte assembler of the frame decoder: tracks the byte position, the running CRC and the
// raw fields, and registers one frame record per seven-byte reply. Depends on htfd_pkg.
module htfd_assembler (
    input  logic             i_clk,
    input  logic             i_rst_n,
    htfd_in_if.sink          i_in,
    input  logic [7:0]       i_busy_mask,
    output logic             o_rec_valid,
    input  logic             i_rec_ready,
    output htfd_pkg::t_frame o_rec
);
    import htfd_pkg::*;

    logic [2:0]  r_pos,  n_pos;
    logic [7:0]  r_crc,  n_crc;
    logic [7:0]  r_stat, n_stat;
    logic [19:0] r_hum,  n_hum;
    logic [19:0] r_temp, n_temp;
    logic        r_rec_valid, n_rec_valid;
    t_frame      r_rec, n_rec;

    logic        accept;
    logic        restart;
    logic [2:0]  pos;
    logic [7:0]  crc;
    logic [7:0]  b;
    logic        last;

    // A new byte is taken whenever the record slot is free or being emptied.
    assign i_in.ready = !r_rec_valid || i_rec_ready;
    assign accept     = i_in.valid && i_in.ready;
    assign b          = i_in.data_byte;

    // Frame start or a stray position restarts the frame at the status byte.
    assign restart = i_in.frame_start || (r_pos > FRAME_LAST);
    assign pos     = restart ? 3'd0 : r_pos;
    assign crc     = restart ? CRC_INIT : r_crc;
    assign last    = (pos == FRAME_LAST);

    // Field assembly, CRC update and frame record.
    always_comb begin
        n_pos       = r_pos;
        n_crc       = r_crc;
        n_stat      = r_stat;
        n_hum       = r_hum;
        n_temp      = r_temp;
        n_rec       = r_rec;
        n_rec_valid = r_rec_valid && !i_rec_ready;
        if (accept) begin
            case (pos)
                3'd0: n_stat = b;
                3'd1: n_hum[19:12] = b;
                3'd2: n_hum[11:4] = b;
                3'd3: begin
                    n_hum[3:0]    = b[7:4];
                    n_temp[19:16] = b[3:0];
                end
                3'd4: n_temp[15:8] = b;
                3'd5: n_temp[7:0] = b;
                default: ;
            endcase
            if (last) begin
                n_pos                 = 3'd0;
                n_crc                 = CRC_INIT;
                n_rec_valid           = 1'b1;
                n_rec.humidity_raw    = r_hum;
                n_rec.temperature_raw = r_temp;
                n_rec.crc_computed    = crc;
                if ((r_stat & i_busy_mask) != 8'd0) begin
                    n_rec.status = STATUS_BUSY;
                end else if (crc != b) begin
                    n_rec.status = STATUS_CRC_ERR;
                end else begin
                    n_rec.status = STATUS_OK;
                end
            end else begin
                n_pos = pos + 3'd1;
                n_crc = crc8_update(crc, b);
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= 3'd0;
            r_crc       <= CRC_INIT;
            r_stat      <= 8'd0;
            r_hum       <= 20'd0;
            r_temp      <= 20'd0;
            r_rec_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_crc       <= n_crc;
            r_stat      <= n_stat;
            r_hum       <= n_hum;
            r_temp      <= n_temp;
            r_rec_valid <= n_rec_valid;
        end
    end

    // Record payload.
    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    assign o_rec_valid = r_rec_valid;
    assign o_rec       = r_rec;

    // The position counter never leaves the frame.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= FRAME_LAST)
        else $error("byte position out of range");

    // The CRC byte closes the frame and raises a record.
    a_frame_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && last) |=> (r_pos == 3'd0 && r_crc == CRC_INIT && r_rec_valid))
        else $error("frame not closed after the CRC byte");

    // A frame start byte moves the position to the first data byte.
    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.frame_start) |=> (r_pos == 3'd1))
        else $error("frame start did not restart the position");

    // A record waiting downstream is not overwritten.
    a_rec_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rec_valid && !i_rec_ready) |=> (r_rec_valid && $stable(r_rec)))
        else $error("pending frame record lost");

endmodule

// ===== rtl/htfd_convert.sv =====
// Conversion stage of the frame decoder: scales the raw fields to hundredths and
// registers the result item. Depends on htfd_pkg and the output channel interface.
module htfd_convert (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rec_valid,
    output logic             o_rec_ready,
    input  htfd_pkg::t_frame i_rec,
    htfd_out_if.source       o_out
);
    import htfd_pkg::*;

    logic               r_valid;
    logic [1:0]         r_status;
    logic [19:0]        r_hum_raw;
    logic [19:0]        r_temp_raw;
    logic [13:0]        r_hum_centi;
    logic signed [14:0] r_temp_centi;
    logic [7:0]         r_crc;

    logic               take;
    logic [33:0]        hum_prod;
    logic [34:0]        temp_prod;
    logic [14:0]        temp_scaled;

    assign o_rec_ready = !r_valid || o_out.ready;
    assign take        = i_rec_valid && o_rec_ready;

    // Fixed-point scaling: multiply, drop 20 fraction bits, then apply the offset.
    assign hum_prod    = {14'd0, i_rec.humidity_raw} * {20'd0, HUM_SCALE};
    assign temp_prod   = {15'd0, i_rec.temperature_raw} * {20'd0, TEMP_SCALE};
    assign temp_scaled = temp_prod[34:20] - TEMP_OFFSET;

    // Output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_rec_ready) begin
            r_valid <= i_rec_valid;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_status     <= i_rec.status;
            r_hum_raw    <= i_rec.humidity_raw;
            r_temp_raw   <= i_rec.temperature_raw;
            r_hum_centi  <= hum_prod[33:20];
            r_temp_centi <= signed'(temp_scaled);
            r_crc        <= i_rec.crc_computed;
        end
    end

    assign o_out.valid             = r_valid;
    assign o_out.status            = r_status;
    assign o_out.humidity_raw      = r_hum_raw;
    assign o_out.temperature_raw   = r_temp_raw;
    assign o_out.humidity_centi    = r_hum_centi;
    assign o_out.temperature_centi = r_temp_centi;
    assign o_out.crc_computed      = r_crc;

    // Only defined status codes leave the block.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_status == STATUS_OK || r_status == STATUS_BUSY
                     || r_status == STATUS_CRC_ERR))
        else $error("undefined status code");

    // A delivered record becomes a result in the next cycle.
    a_take_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> (r_valid && r_crc == $past(i_rec.crc_computed)))
        else $error("record not registered as a result");

endmodule
